/* sv/gcsr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the gradient colour-stop ramp.
// No dependencies; used by the top level and its checker.
package gcsr_pkg;

    localparam int MAX_STOPS_DEF = 16;

    localparam int POS_W    = 16;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int COLOUR_W = CHAN_W * NUM_CHAN;
    localparam int STATUS_W = 2;

    // datapath widths: c*w sums, 2n+d, 2d << 7
    localparam int ACC_W = CHAN_W + POS_W;
    localparam int REM_W = ACC_W + 2;
    localparam int DEN_W = POS_W + 1 + CHAN_W - 1;

    localparam logic OP_ADD = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_COLOUR  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [COLOUR_W-1:0] colour;
    } stop_t;

endpackage

/* sv/gradient_color_stop_ramp_top.sv */
`timescale 1ns / 1ps
// Gradient colour-stop ramp: sorted stop table in one synchronous RAM,
// insertion by shift-down scan, lookup by upward scan and lane interpolation.
// Depends on gcsr_pkg.
//
//  channel | handshake         | payload
//  --------+-------------------+-----------------------------------------------
//  s_      | s_valid / s_ready | opcode, position, red/green/blue/alpha_in
//  m_      | m_valid / m_ready | status, red/green/blue/alpha_out
//
// One item at a time; s_ready is high only while the sequencer is idle.
// Add: a downward scan shifts up each stop above the new position; a drop skips it.
// Lookup: an upward scan reads stops in order until one lies above the position;
// interpolation then takes eight shared 8x16 multiply steps, setup, eight divide steps.
// Reset (aresetn low, synchronous) empties the table; entries are not cleared.
// A stalled m_ holds its item; the next item may be taken, its result waits here.
module gradient_color_stop_ramp_top #(
    parameter int MAX_STOPS = gcsr_pkg::MAX_STOPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [gcsr_pkg::POS_W-1:0]    s_position,
    input  logic [gcsr_pkg::CHAN_W-1:0]   s_red_in,
    input  logic [gcsr_pkg::CHAN_W-1:0]   s_green_in,
    input  logic [gcsr_pkg::CHAN_W-1:0]   s_blue_in,
    input  logic [gcsr_pkg::CHAN_W-1:0]   s_alpha_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcsr_pkg::STATUS_W-1:0] m_status,
    output logic [gcsr_pkg::CHAN_W-1:0]   m_red_out,
    output logic [gcsr_pkg::CHAN_W-1:0]   m_green_out,
    output logic [gcsr_pkg::CHAN_W-1:0]   m_blue_out,
    output logic [gcsr_pkg::CHAN_W-1:0]   m_alpha_out
);
    import gcsr_pkg::*;

    localparam int IDX_W = $clog2(MAX_STOPS);
    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int STEP_W = $clog2(2 * NUM_CHAN);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ADD_SCAN, ST_ADD_LAST, ST_LK_SCAN,
        ST_MUL, ST_DIV_LOAD, ST_DIV, ST_FIN
    } state_t;

    function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOUR_W-1:0] col,
                                                  input logic [1:0] idx);
        logic [COLOUR_W-1:0] sh;
        sh = col << (CHAN_W * idx);
        return sh[COLOUR_W-1 -: CHAN_W];
    endfunction

    // stop table
    stop_t            mem [MAX_STOPS];
    stop_t            rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wa;
    stop_t            wd;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t                             state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [POS_W-1:0]                   pos_reg, pos_next;
    logic [COLOUR_W-1:0]                colour_reg, colour_next;
    logic [IDX_W-1:0]                   k_reg, k_next;
    logic [CNT_W-1:0]                   j_reg, j_next;
    stop_t                              prev_reg, prev_next;
    logic [COLOUR_W-1:0]                c1_reg, c1_next;
    logic [POS_W-1:0]                   w0_reg, w0_next;
    logic [POS_W-1:0]                   w1_reg, w1_next;
    logic [POS_W-1:0]                   d_reg, d_next;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic [NUM_CHAN-1:0][ACC_W-1:0]     acc_reg, acc_next;
    logic [NUM_CHAN-1:0][REM_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]                   den_reg, den_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]    q_reg, q_next;
    logic [STATUS_W-1:0]                status_reg, status_next;
    logic                               m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]                m_status_reg, m_status_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]    m_chan_reg, m_chan_next;

    logic [1:0]       mul_ch;
    logic [CHAN_W-1:0] mul_c;
    logic [POS_W-1:0] mul_w;
    logic [ACC_W-1:0] mul_prod;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] j_inc;

    assign mul_ch   = step_reg[STEP_W-1 -: 2];
    assign mul_c    = step_reg[0] ? chan_of(c1_reg, mul_ch) : chan_of(prev_reg.colour, mul_ch);
    assign mul_w    = step_reg[0] ? w1_reg : w0_reg;
    assign mul_prod = {{POS_W{1'b0}}, mul_c} * {{CHAN_W{1'b0}}, mul_w};
    assign count_m1 = count_reg - CNT_W'(1);
    assign j_inc    = j_reg + CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        colour_next   = colour_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        prev_next     = prev_reg;
        c1_next       = c1_reg;
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        d_next        = d_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        q_next        = q_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_chan_next   = m_chan_reg;
        rd_addr       = '0;
        we            = 1'b0;
        wa            = '0;
        wd            = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_next    = s_position;
                    colour_next = {s_red_in, s_green_in, s_blue_in, s_alpha_in};
                    q_next      = '0;
                    if (s_opcode == OP_ADD) begin
                        if (count_reg == CNT_W'(MAX_STOPS)) begin
                            status_next = STATUS_DROPPED;
                            state_next  = ST_FIN;
                        end else begin
                            status_next = STATUS_STORED;
                            if (count_reg == '0) begin
                                state_next = ST_ADD_LAST;
                            end else begin
                                k_next     = count_reg[IDX_W-1:0];
                                rd_addr    = count_m1[IDX_W-1:0];
                                state_next = ST_ADD_SCAN;
                            end
                        end
                    end else begin
                        status_next = STATUS_COLOUR;
                        if (count_reg == '0) begin
                            state_next = ST_FIN;
                        end else begin
                            j_next     = '0;
                            state_next = ST_LK_SCAN;
                        end
                    end
                end
            end
            ST_ADD_SCAN: begin
                we = 1'b1;
                wa = k_reg;
                if (rd_data_reg.pos <= pos_reg) begin
                    wd         = '{pos: pos_reg, colour: colour_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_FIN;
                end else begin
                    wd = rd_data_reg;
                    if (k_reg == IDX_W'(1)) begin
                        state_next = ST_ADD_LAST;
                    end else begin
                        k_next  = k_reg - IDX_W'(1);
                        rd_addr = k_reg - IDX_W'(2);
                    end
                end
            end
            ST_ADD_LAST: begin
                we         = 1'b1;
                wa         = '0;
                wd         = '{pos: pos_reg, colour: colour_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = ST_FIN;
            end
            ST_LK_SCAN: begin
                if (j_reg == count_reg) begin
                    for (int l = 0; l < NUM_CHAN; l++) begin
                        q_next[l] = chan_of(prev_reg.colour, 2'(l));
                    end
                    state_next = ST_FIN;
                end else if (j_reg == '0 && pos_reg <= rd_data_reg.pos) begin
                    for (int l = 0; l < NUM_CHAN; l++) begin
                        q_next[l] = chan_of(rd_data_reg.colour, 2'(l));
                    end
                    state_next = ST_FIN;
                end else if (j_reg != '0 && rd_data_reg.pos > pos_reg) begin
                    w0_next    = rd_data_reg.pos - pos_reg;
                    w1_next    = pos_reg - prev_reg.pos;
                    d_next     = rd_data_reg.pos - prev_reg.pos;
                    c1_next    = rd_data_reg.colour;
                    step_next  = '0;
                    state_next = ST_MUL;
                end else begin
                    prev_next = rd_data_reg;
                    j_next    = j_inc;
                    rd_addr   = j_inc[IDX_W-1:0];
                end
            end
            ST_MUL: begin
                acc_next[mul_ch] = (step_reg[0] ? acc_reg[mul_ch] : '0) + mul_prod;
                step_next        = step_reg + STEP_W'(1);
                if (step_reg == '1) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                // numerator 2n + d, divisor 2d aligned to the top quotient bit
                for (int l = 0; l < NUM_CHAN; l++) begin
                    rem_next[l] = {1'b0, acc_reg[l], 1'b0} + {{(REM_W-POS_W){1'b0}}, d_reg};
                end
                den_next   = {d_reg, 1'b0, {(CHAN_W-1){1'b0}}};
                step_next  = '0;
                q_next     = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                for (int l = 0; l < NUM_CHAN; l++) begin
                    if (rem_reg[l] >= {{(REM_W-DEN_W){1'b0}}, den_reg}) begin
                        rem_next[l] = rem_reg[l] - {{(REM_W-DEN_W){1'b0}}, den_reg};
                        q_next[l]   = {q_reg[l][CHAN_W-2:0], 1'b1};
                    end else begin
                        q_next[l]   = {q_reg[l][CHAN_W-2:0], 1'b0};
                    end
                end
                den_next  = den_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CHAN_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_chan_next   = q_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        colour_reg   <= colour_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        prev_reg     <= prev_next;
        c1_reg       <= c1_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        d_reg        <= d_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        q_reg        <= q_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_chan_reg   <= m_chan_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_red_out   = m_chan_reg[0];
    assign m_green_out = m_chan_reg[1];
    assign m_blue_out  = m_chan_reg[2];
    assign m_alpha_out = m_chan_reg[3];

endmodule

/* sv/gcsr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the gradient colour-stop ramp, bound to the top.
// Depends on gcsr_pkg.
module gcsr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [gcsr_pkg::STATUS_W-1:0] m_status,
    input logic [gcsr_pkg::CHAN_W-1:0]   m_red_out,
    input logic [gcsr_pkg::CHAN_W-1:0]   m_green_out,
    input logic [gcsr_pkg::CHAN_W-1:0]   m_blue_out,
    input logic [gcsr_pkg::CHAN_W-1:0]   m_alpha_out
);
    import gcsr_pkg::*;

    // one item in flight: the sequencer leaves idle on every accepted item
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous item still in progress");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_COLOUR || m_status == STATUS_STORED ||
                     m_status == STATUS_DROPPED))
        else $error("unknown status code");

    a_add_no_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_COLOUR |->
            m_red_out == '0 && m_green_out == '0 && m_blue_out == '0 && m_alpha_out == '0)
        else $error("add item result carries colour");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_red_out) &&
            $stable(m_green_out) && $stable(m_blue_out) && $stable(m_alpha_out))
        else $error("stalled result changed");

endmodule

bind gradient_color_stop_ramp_top gcsr_checker u_gcsr_checker (.*);
